// ----- design/rgoc_pkg.sv -----
// Package: shared types and constants for the read gene overlap counter.
package rgoc_pkg;

  localparam int unsigned MaxGenesDefault = 256;
  localparam logic [7:0]  QualityReset    = 8'd20;
  localparam logic [31:0] Sat32           = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeRead  = 2'd1,
    ModeQuery = 2'd2,
    ModeAlt   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StLoaded  = 3'd0,
    StPoor    = 3'd1,
    StAbsent  = 3'd2,
    StAssoc   = 3'd3,
    StOutside = 3'd4,
    StQuery   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmClear,
    FsmScan,
    FsmFinish,
    FsmQuery,
    FsmOut
  } fsm_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch input item
    logic load;       // write gene slot
    logic scan_start; // begin gene sweep
    logic scan_step;  // process one slot
    logic clear_step; // step the reset pass pointer
    logic finish;     // finalize read item
    logic query_rd;   // read query slot
    logic query_out;  // form query result
    logic out_load;   // present result
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic clear_last;
    logic poor;
  } stat_t;

endpackage

// ----- design/read_gene_overlap_counter_core.sv -----
// Top level: read gene overlap counter with config register.
//
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | mode, gene index, ref, coords, span, quality
// out     | out_valid/out_stall| status, slot counters, global counters
// cfg     | cfg_valid/cfg_ready| quality threshold
//
// A read sweeps the gene table through its memory port one slot per cycle; a
// poor read skips the sweep. After reset the valid bits clear at once; a clear
// pass through the table holds in_stall high before the first item. The result
// register holds under out_stall; the next item may be taken while it waits,
// and that item's result holds in_stall high until the register is handed over.
module read_gene_overlap_counter_core
  import rgoc_pkg::*;
#(
  parameter int unsigned MaxGenes = MaxGenesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  gene_index_i,
  input  logic [7:0]  ref_id_i,
  input  logic [30:0] start_pos_i,
  input  logic [30:0] gene_end_i,
  input  logic [23:0] aligned_span_i,
  input  logic [7:0]  mapping_quality_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status_o,
  output logic [31:0] reads_within_o,
  output logic [31:0] reads_left_o,
  output logic [31:0] reads_right_o,
  output logic [31:0] total_reads_o,
  output logic [31:0] poor_quality_reads_o,
  output logic [31:0] outside_reads_o,
  output logic        slot_loaded_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;
  logic [7:0] thr_q;
  logic full;

  assign cfg_ready = 1'b1;
  assign out_valid = full;

  // Hold the quality threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= QualityReset;
    else if (cfg_valid) thr_q <= cfg_data_i;
  end

  rgoc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .mode_i,
    .out_full_i(full), .stat_i(stat), .ctrl_o(ctrl)
  );

  rgoc_dp #(.MaxGenes(MaxGenes)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .threshold_i(thr_q),
    .mode_i, .gene_index_i, .ref_id_i, .start_pos_i, .gene_end_i,
    .aligned_span_i, .mapping_quality_i,
    .out_full_o(full), .out_stall_i(out_stall),
    .status_o, .reads_within_o, .reads_left_o, .reads_right_o,
    .total_reads_o, .poor_quality_reads_o, .outside_reads_o, .slot_loaded_o
  );

endmodule

// ----- design/rgoc_ctrl.sv -----
// Controller: sequences load, clear sweep, gene scan, query and output.
module rgoc_ctrl
  import rgoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode_i,
  input  logic        out_full_i,
  input  stat_t       stat_i,
  output ctrl_t       ctrl_o
);

  fsm_e state_q, state_d;
  logic accept;

  assign accept = (state_q == FsmIdle) && in_valid;
  assign in_stall = (state_q != FsmIdle);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmClear: if (stat_i.clear_last) state_d = FsmIdle;
      FsmIdle: begin
        if (in_valid) begin
          case (mode_e'(mode_i))
            ModeLoad: state_d = FsmOut;
            ModeRead: state_d = FsmScan;
            default:  state_d = FsmQuery;
          endcase
        end
      end
      FsmScan:   if (stat_i.poor || stat_i.scan_last) state_d = FsmFinish;
      FsmFinish: state_d = FsmOut;
      FsmQuery:  state_d = FsmOut;
      FsmOut:    if (!out_full_i) state_d = FsmIdle;
      default:   state_d = FsmIdle;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      FsmClear: ctrl_o.clear_step = 1'b1;
      FsmIdle: begin
        ctrl_o.capture = accept;
        ctrl_o.load = accept && (mode_e'(mode_i) == ModeLoad);
        ctrl_o.scan_start = accept;
      end
      FsmScan:   ctrl_o.scan_step = !stat_i.poor;
      FsmFinish: ctrl_o.finish = 1'b1;
      FsmQuery:  ctrl_o.query_out = 1'b1;
      FsmOut:    ctrl_o.out_load = !out_full_i;
      default:   ctrl_o = '0;
    endcase
    ctrl_o.query_rd = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FsmClear;
    else         state_q <= state_d;
  end

endmodule

// ----- design/rgoc_dp.sv -----
// Datapath: gene table memory, counters, scan compare and result register.
module rgoc_dp
  import rgoc_pkg::*;
#(
  parameter int unsigned MaxGenes = MaxGenesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output stat_t       stat_o,
  input  logic [7:0]  threshold_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  gene_index_i,
  input  logic [7:0]  ref_id_i,
  input  logic [30:0] start_pos_i,
  input  logic [30:0] gene_end_i,
  input  logic [23:0] aligned_span_i,
  input  logic [7:0]  mapping_quality_i,
  output logic        out_full_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] reads_within_o,
  output logic [31:0] reads_left_o,
  output logic [31:0] reads_right_o,
  output logic [31:0] total_reads_o,
  output logic [31:0] poor_quality_reads_o,
  output logic [31:0] outside_reads_o,
  output logic        slot_loaded_o
);

  localparam int unsigned AW = (MaxGenes > 1) ? $clog2(MaxGenes) : 1;
  localparam int unsigned CW = $clog2(MaxGenes + 1);
  localparam logic [CW-1:0] LastIdx = CW'(MaxGenes - 1);

  typedef struct packed {
    logic [7:0]  gref;
    logic [30:0] gs;
    logic [30:0] ge;
    logic [31:0] cw;
    logic [31:0] cl;
    logic [31:0] cr;
  } entry_t;

  entry_t mem_q [MaxGenes];
  logic [MaxGenes-1:0] valid_q;

  // latched item
  logic [1:0]  mode_q;
  logic [7:0]  idx_q, ref_q;
  logic [30:0] rs_q;
  logic [31:0] re_q; // start + span - 1 as 33-bit signed folded below
  logic        re_neg_q;
  logic        poor_q;
  logic [CW-1:0] ptr_q;
  logic        found_q, assoc_q;
  logic [31:0] tot_q, poor_cnt_q, outs_q;

  // pipelined slot read
  entry_t      rd_q;
  logic        rd_v_q;
  logic [AW-1:0] rd_a_q;
  logic        idx_in_range;

  logic [32:0] re_full;
  assign re_full = {2'b0, start_pos_i} + {9'b0, aligned_span_i} - 33'd1;
  assign idx_in_range = ({24'b0, idx_q} < 32'(MaxGenes));

  function automatic logic [31:0] sat(input logic [31:0] v);
    return (v == Sat32) ? v : v + 32'd1;
  endfunction

  // Classification of the slot read last cycle
  logic sc_hit, c_w, c_l, c_r;
  logic [32:0] gs_x, ge_x, rs_x, re_x;
  always_comb begin
    gs_x = {2'b0, rd_q.gs};
    ge_x = {2'b0, rd_q.ge};
    rs_x = {2'b0, rs_q};
    re_x = re_neg_q ? 33'h1_FFFF_FFFF : {1'b0, re_q};
    sc_hit = rd_v_q && (rd_q.gref == ref_q);
    // signed compare with re possibly -1
    c_w = ($signed(gs_x) <= $signed(rs_x)) && ($signed(ge_x) >= $signed(re_x));
    c_l = !c_w && ($signed(gs_x) > $signed(rs_x)) && ($signed(gs_x) <= $signed(re_x));
    c_r = !c_w && !c_l && ($signed(ge_x) >= $signed(rs_x))
          && ($signed(ge_x) < $signed(re_x));
  end

  logic scan_pend_q; // a read is in rd_q to classify
  assign stat_o.poor       = poor_q;
  assign stat_o.scan_last  = (ptr_q == CW'(MaxGenes));
  assign stat_o.clear_last = (ptr_q == LastIdx);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ptr_q       <= '0;
      tot_q       <= '0;
      poor_cnt_q  <= '0;
      outs_q      <= '0;
      out_full_o  <= 1'b0;
      scan_pend_q <= 1'b0;
      found_q     <= 1'b0;
      assoc_q     <= 1'b0;
      poor_q      <= 1'b0;
    end else begin
      if (ctrl_i.clear_step) ptr_q <= ptr_q + CW'(1);
      if (ctrl_i.capture) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
        assoc_q <= 1'b0;
        poor_q  <= (mode_e'(mode_i) == ModeRead) && (mapping_quality_i < threshold_i);
        if (mode_e'(mode_i) == ModeRead) begin
          tot_q <= sat(tot_q);
          if (mapping_quality_i < threshold_i) poor_cnt_q <= sat(poor_cnt_q);
        end
      end
      if (ctrl_i.load && ({24'b0, gene_index_i} < 32'(MaxGenes)))
        valid_q[gene_index_i[AW-1:0]] <= 1'b1;
      scan_pend_q <= ctrl_i.scan_step && (ptr_q < CW'(MaxGenes));
      if (ctrl_i.scan_step && (ptr_q < CW'(MaxGenes))) ptr_q <= ptr_q + CW'(1);
      if (scan_pend_q && sc_hit) begin
        found_q <= 1'b1;
        if (c_w || c_l || c_r) assoc_q <= 1'b1;
      end
      if (ctrl_i.finish && !poor_q && mode_e'(mode_q) == ModeRead
          && found_q && !assoc_q)
        outs_q <= sat(outs_q);
      if (ctrl_i.out_load) out_full_o <= 1'b1;
      else if (!out_stall_i) out_full_o <= 1'b0;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      mode_q   <= mode_i;
      idx_q    <= gene_index_i;
      ref_q    <= ref_id_i;
      rs_q     <= start_pos_i;
      re_q     <= re_full[31:0];
      re_neg_q <= re_full[32];
    end
    if (ctrl_i.load && ({24'b0, gene_index_i} < 32'(MaxGenes)))
      mem_q[gene_index_i[AW-1:0]] <= '{ref_id_i, start_pos_i, gene_end_i,
                                       32'd0, 32'd0, 32'd0};
    else if (scan_pend_q && sc_hit) begin
      if (c_w) mem_q[rd_a_q].cw <= sat(rd_q.cw);
      if (c_l) mem_q[rd_a_q].cl <= sat(rd_q.cl);
      if (c_r) mem_q[rd_a_q].cr <= sat(rd_q.cr);
    end
    // Read the query slot at accept, sweep slots during scan, hold otherwise
    if (ctrl_i.query_rd) begin
      rd_q   <= mem_q[gene_index_i[AW-1:0]];
      rd_v_q <= ({24'b0, gene_index_i} < 32'(MaxGenes))
                && valid_q[gene_index_i[AW-1:0]];
    end else if (ctrl_i.scan_step) begin
      rd_q   <= mem_q[ptr_q[AW-1:0]];
      rd_v_q <= (ptr_q < CW'(MaxGenes)) && valid_q[ptr_q[AW-1:0]];
    end
    rd_a_q <= ptr_q[AW-1:0];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      total_reads_o        <= tot_q;
      poor_quality_reads_o <= poor_cnt_q;
      outside_reads_o      <= outs_q;
      reads_within_o <= '0;
      reads_left_o   <= '0;
      reads_right_o  <= '0;
      slot_loaded_o  <= 1'b0;
      case (mode_e'(mode_q))
        ModeLoad: status_o <= StLoaded;
        ModeRead: begin
          if (poor_q)        status_o <= StPoor;
          else if (!found_q) status_o <= StAbsent;
          else if (assoc_q)  status_o <= StAssoc;
          else               status_o <= StOutside;
        end
        default: begin
          status_o <= StQuery;
          if (idx_in_range && rd_v_q) begin
            reads_within_o <= rd_q.cw;
            reads_left_o   <= rd_q.cl;
            reads_right_o  <= rd_q.cr;
            slot_loaded_o  <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule
